// File: src/rmg_pkg.sv
package rmg_pkg;

    // Angle input: signed Q3.12, low ANGLE_WIDTH bits used (ANGLE_WIDTH <= 16 here).
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 14;
    localparam int ATAN_LEN      = 30;
    localparam int NSTAGE        = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    // Q12 -> Q30 shift
    localparam int Q_SHIFT = 18;
    // scaled angle width: one sign bit over +-2^(ANGLE_WIDTH+17), and room for two pi
    localparam int ZW = (ANGLE_WIDTH + Q_SHIFT + 1 > 35) ? ANGLE_WIDTH + Q_SHIFT + 1 : 35;
    // CORDIC datapath width (Q30, values stay below 2^32 in magnitude)
    localparam int CW = 34;

    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_GAIN    = 64'sd652032874;
    localparam longint ROUND_HALF  = 64'sd32768;

    localparam int ELEM_W = 16;
    localparam logic signed [ELEM_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic signed [ELEM_W-1:0] NEG_ONE_Q14 = -16'sd16384;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef logic [1:0] row_t;
    localparam row_t ROW_LAST = 2'd3;

    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

    // reduced and folded angle, into the CORDIC
    typedef struct packed {
        axis_t                 mode;
        logic                  neg;
        logic signed [CW-1:0]  z;
    } reduce_t;

    // CORDIC result, before sign fix and rounding
    typedef struct packed {
        axis_t                 mode;
        logic                  neg;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
    } cord_t;

    // final cosine/sine in Q1.14
    typedef struct packed {
        axis_t                     mode;
        logic signed [ELEM_W-1:0]  cos_q;
        logic signed [ELEM_W-1:0]  sin_q;
    } trig_t;

endpackage

// File: src/axis_rotation_matrix_generator_unit.sv
// Pipeline: an accepted angle word passes 3 reduce, 14 CORDIC, 2 round and 1 row register
//   stages before its first row word; rows 1..3 follow, each once the one before is taken.
// New angles enter as earlier rows drain; the single row port emits one row a cycle unless stalled.
// Reset: rst_n is asynchronous, active low; it empties every stage and clears the
//   held cosine, sine, axis and row counter. Datapath registers are not reset.
module axis_rotation_matrix_generator_unit (
    input  logic         clk,
    input  logic         rst_n,
    // input angle words
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] angle (signed Q3.12)
    input  logic [1:0]   s_axis_tuser,   // [1:0] mode (0 = x, 1 = y, 2 = z)
    // output row words
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [15:0] col0, [31:16] col1, [47:32] col2, [63:48] col3
    output logic [1:0]   m_axis_tuser,   // [1:0] row_index
    output logic         m_axis_tlast
);
    import rmg_pkg::*;

    // Flow: every stage holds a valid bit and loads when it is empty or its
    // successor takes its word, so bubbles collapse and stalls back up cleanly.

    logic     red_valid, red_ready;
    reduce_t  red_item;
    logic     cor_valid, cor_ready;
    cord_t    cor_item;
    logic     pst_valid, pst_ready;
    trig_t    pst_item;

    // angle scaling, wrap into (-pi, pi], fold into [-pi/2, pi/2]
    rmg_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_angle  (s_axis_tdata[ANGLE_WIDTH-1:0]),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_item  (red_item)
    );

    // one CORDIC micro-rotation per stage
    rmg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_item   (red_item),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_item  (cor_item)
    );

    // undo the fold sign, then round and clamp to Q1.14
    rmg_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_valid),
        .in_ready  (cor_ready),
        .in_item   (cor_item),
        .out_valid (pst_valid),
        .out_ready (pst_ready),
        .out_item  (pst_item)
    );

    // holds cos/sin/axis and walks the four rows out
    rmg_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pst_valid),
        .in_ready  (pst_ready),
        .in_item   (pst_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (m_axis_tuser),
        .out_cols  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// File: src/rmg_reduce.sv
module rmg_reduce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rmg_pkg::axis_t                    in_mode,
    input  logic [rmg_pkg::ANGLE_WIDTH-1:0]   in_angle,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rmg_pkg::reduce_t                  out_item
);
    import rmg_pkg::*;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(Q30_PI);
    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(Q30_TWO_PI);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(Q30_HALF_PI);

    logic                  v0_reg, v1_reg, v2_reg;
    logic                  rdy0, rdy1, rdy2;
    axis_t                 m0_reg, m1_reg;
    logic signed [ZW-1:0]  z0_reg, z1_reg;
    logic signed [ZW-1:0]  z0_next, z1_next, z2_wide;
    reduce_t               item_reg, item_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    // sign extend and scale Q12 -> Q30
    assign z0_next = {{(ZW-ANGLE_WIDTH-Q_SHIFT){in_angle[ANGLE_WIDTH-1]}},
                      in_angle, {Q_SHIFT{1'b0}}};

    // one wrap by two pi lands in (-pi, pi]
    always_comb
    begin
        if (z0_reg > PI_Z)
            z1_next = z0_reg - TWO_PI_Z;
        else if (z0_reg <= -PI_Z)
            z1_next = z0_reg + TWO_PI_Z;
        else
            z1_next = z0_reg;
    end

    // fold into [-pi/2, pi/2], flip sign of both outputs
    always_comb
    begin
        item_next.mode = m1_reg;
        if (z1_reg > HALF_PI_Z)
        begin
            z2_wide        = z1_reg - PI_Z;
            item_next.neg  = 1'b1;
        end
        else if (z1_reg < -HALF_PI_Z)
        begin
            z2_wide        = z1_reg + PI_Z;
            item_next.neg  = 1'b1;
        end
        else
        begin
            z2_wide        = z1_reg;
            item_next.neg  = 1'b0;
        end
        item_next.z = z2_wide[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
                v0_reg <= in_valid;
            if (rdy1)
                v1_reg <= v0_reg;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            m0_reg <= in_mode;
            z0_reg <= z0_next;
        end
        if (rdy1)
        begin
            m1_reg <= m0_reg;
            z1_reg <= z1_next;
        end
        if (rdy2)
            item_reg <= item_next;
    end

    assign out_valid = v2_reg;
    assign out_item  = item_reg;

endmodule

// File: src/rmg_cordic.sv
module rmg_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rmg_pkg::reduce_t   in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rmg_pkg::cord_t     out_item
);
    import rmg_pkg::*;

    logic                  v_reg    [NSTAGE];
    logic                  rdy      [NSTAGE];
    axis_t                 mode_reg [NSTAGE];
    logic                  neg_reg  [NSTAGE];
    logic signed [CW-1:0]  x_reg    [NSTAGE];
    logic signed [CW-1:0]  y_reg    [NSTAGE];
    logic signed [CW-1:0]  z_reg    [NSTAGE];

    assign in_ready = rdy[0];

    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_stage
        logic                  vi, negi;
        axis_t                 modei;
        logic signed [CW-1:0]  xi, yi, zi, x_next, y_next, z_next, ang;

        if (i == 0)
        begin : g_first
            assign vi    = in_valid;
            assign modei = in_item.mode;
            assign negi  = in_item.neg;
            assign xi    = CW'(Q30_GAIN);
            assign yi    = '0;
            assign zi    = in_item.z;
        end
        else
        begin : g_next
            assign vi    = v_reg[i-1];
            assign modei = mode_reg[i-1];
            assign negi  = neg_reg[i-1];
            assign xi    = x_reg[i-1];
            assign yi    = y_reg[i-1];
            assign zi    = z_reg[i-1];
        end

        if (i == NSTAGE - 1)
        begin : g_rdy_last
            assign rdy[i] = !v_reg[i] || out_ready;
        end
        else
        begin : g_rdy_mid
            assign rdy[i] = !v_reg[i] || rdy[i+1];
        end

        assign ang = signed'(CW'(ATAN_Q30[i]));

        always_comb
        begin
            if (!zi[CW-1])
            begin
                x_next = xi - (yi >>> i);
                y_next = yi + (xi >>> i);
                z_next = zi - ang;
            end
            else
            begin
                x_next = xi + (yi >>> i);
                y_next = yi - (xi >>> i);
                z_next = zi + ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (rdy[i])
                v_reg[i] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                mode_reg[i] <= modei;
                neg_reg[i]  <= negi;
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
            end
        end
    end

    assign out_valid     = v_reg[NSTAGE-1];
    assign out_item.mode = mode_reg[NSTAGE-1];
    assign out_item.neg  = neg_reg[NSTAGE-1];
    assign out_item.x    = x_reg[NSTAGE-1];
    assign out_item.y    = y_reg[NSTAGE-1];

endmodule

// File: src/rmg_post.sv
module rmg_post (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rmg_pkg::cord_t     in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output rmg_pkg::trig_t     out_item
);
    import rmg_pkg::*;

    localparam int SW = CW - 16;

    logic                  va_reg, vb_reg;
    logic                  rdya, rdyb;
    axis_t                 ma_reg;
    logic signed [CW-1:0]  xa_reg, ya_reg;
    trig_t                 item_reg, item_next;

    // round Q30 to Q14 and clamp to +-1.0
    function automatic logic signed [ELEM_W-1:0] to_q14(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        logic signed [SW-1:0] s;
        r = v + CW'(ROUND_HALF);
        s = SW'(r >>> 16);
        if (s > SW'(ONE_Q14))
            return ONE_Q14;
        else if (s < SW'(NEG_ONE_Q14))
            return NEG_ONE_Q14;
        else
            return s[ELEM_W-1:0];
    endfunction

    assign rdyb     = !vb_reg || out_ready;
    assign rdya     = !va_reg || rdyb;
    assign in_ready = rdya;

    always_comb
    begin
        item_next.mode  = ma_reg;
        item_next.cos_q = to_q14(xa_reg);
        item_next.sin_q = to_q14(ya_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdya)
                va_reg <= in_valid;
            if (rdyb)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdya)
        begin
            ma_reg <= in_item.mode;
            xa_reg <= in_item.neg ? -in_item.x : in_item.x;
            ya_reg <= in_item.neg ? -in_item.y : in_item.y;
        end
        if (rdyb)
            item_reg <= item_next;
    end

    assign out_valid = vb_reg;
    assign out_item  = item_reg;

endmodule

// File: src/rmg_rows.sv
module rmg_rows (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  rmg_pkg::trig_t                    in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output rmg_pkg::row_t                     out_row,
    output logic [4*rmg_pkg::ELEM_W-1:0]      out_cols,
    output logic                              out_last
);
    import rmg_pkg::*;

    logic                      valid_reg;
    logic signed [ELEM_W-1:0]  cos_hold_reg, sin_hold_reg;
    axis_t                     axis_hold_reg;
    row_t                      row_count_reg;
    logic                      fire, last_fire;
    logic signed [ELEM_W-1:0]  c, s, ns;
    logic signed [ELEM_W-1:0]  col [4];

    assign fire      = valid_reg && out_ready;
    assign last_fire = fire && (row_count_reg == ROW_LAST);
    assign in_ready  = !valid_reg || last_fire;

    assign c  = cos_hold_reg;
    assign s  = sin_hold_reg;
    assign ns = -sin_hold_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            col[k] = (row_count_reg == row_t'(k)) ? ONE_Q14 : '0;
        case (axis_hold_reg)
            AXIS_X:
            begin
                if (row_count_reg == 2'd1)
                begin
                    col[1] = c;
                    col[2] = s;
                end
                else if (row_count_reg == 2'd2)
                begin
                    col[1] = ns;
                    col[2] = c;
                end
            end
            AXIS_Y:
            begin
                if (row_count_reg == 2'd0)
                begin
                    col[0] = c;
                    col[2] = ns;
                end
                else if (row_count_reg == 2'd2)
                begin
                    col[0] = s;
                    col[2] = c;
                end
            end
            AXIS_Z:
            begin
                if (row_count_reg == 2'd0)
                begin
                    col[0] = c;
                    col[1] = s;
                end
                else if (row_count_reg == 2'd1)
                begin
                    col[0] = ns;
                    col[1] = c;
                end
            end
            default:
            begin
                // undefined axis: identity
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            row_count_reg <= '0;
            cos_hold_reg  <= '0;
            sin_hold_reg  <= '0;
            axis_hold_reg <= AXIS_X;
        end
        else
        begin
            if (fire)
                row_count_reg <= row_count_reg + 2'd1;
            if (in_ready)
                valid_reg <= in_valid;
            if (in_ready && in_valid)
            begin
                cos_hold_reg  <= in_item.cos_q;
                sin_hold_reg  <= in_item.sin_q;
                axis_hold_reg <= in_item.mode;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_row   = row_count_reg;
    assign out_cols  = {col[3], col[2], col[1], col[0]};
    assign out_last  = (row_count_reg == ROW_LAST);

endmodule

// File: src/rmg_checker.sv
module rmg_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    input  logic         m_axis_tlast
);
    import rmg_pkg::*;

    // a stalled row word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("row word changed while stalled");

    // last marks row 3 and only row 3
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == ROW_LAST)))
        else $error("tlast does not match row index");

    // row 3 is always [0 0 0 1]
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ROW_LAST |->
            m_axis_tdata[63:48] == ONE_Q14 && m_axis_tdata[47:0] == 48'd0)
        else $error("bottom row is not homogeneous");

    // column 3 of the rotation rows is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != ROW_LAST |-> m_axis_tdata[63:48] == 16'd0)
        else $error("translation column not zero");

endmodule

bind axis_rotation_matrix_generator_unit rmg_checker u_rmg_checker (.*);
